>>> hw/rtl/pcmi_pkg.sv
// Shared types, format codes and G.711 expansion functions for the sample converter.
`default_nettype none

package pcmi_pkg;

    // Sample format codes
    localparam logic [2:0] FMT_S_LE = 3'd0;
    localparam logic [2:0] FMT_S_BE = 3'd1;
    localparam logic [2:0] FMT_U_LE = 3'd2;
    localparam logic [2:0] FMT_U_BE = 3'd3;
    localparam logic [2:0] FMT_ALAW = 3'd4;
    localparam logic [2:0] FMT_ULAW = 3'd5;

    // Configuration register indexes
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_BITS   = 1'b1;

    // Reset values
    localparam logic [2:0] FORMAT_RESET = FMT_S_LE;
    localparam logic [5:0] BITS_RESET   = 6'd16;

    // Constants of the conversions
    localparam logic [7:0]  ALAW_XOR      = 8'h55;
    localparam logic [15:0] ALAW_SEG_BIAS = 16'h0108;
    localparam logic [15:0] ALAW_SEG0_ADD = 16'h0008;
    localparam logic [15:0] ULAW_BIAS     = 16'h0084;
    localparam logic [31:0] UNSIGNED_OFFS = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0] sample_format;
        logic [5:0] sample_bits;
    } cfg_t;

    // Expand one A-law code to a 16-bit linear value
    function automatic logic [15:0] alaw_expand(input logic [7:0] code);
        logic [7:0]  a;
        logic [2:0]  seg;
        logic [15:0] mag;
        a   = code ^ ALAW_XOR;
        seg = a[6:4];
        mag = {8'h00, a[3:0], 4'h0};
        if (seg == 3'd0) begin
            mag = mag + ALAW_SEG0_ADD;
        end else begin
            mag = mag + ALAW_SEG_BIAS;
            if (seg > 3'd1) begin
                mag = mag << (seg - 3'd1);
            end
        end
        return a[7] ? mag : (16'h0000 - mag);
    endfunction

    // Expand one mu-law code to a 16-bit linear value
    function automatic logic [15:0] ulaw_expand(input logic [7:0] code);
        logic [7:0]  u;
        logic [15:0] t;
        u = ~code;
        t = ({9'h000, u[3:0], 3'b000} + ULAW_BIAS) << u[6:4];
        return u[7] ? (ULAW_BIAS - t) : (t - ULAW_BIAS);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pcmi_convert.sv
// Combinational conversion of one raw sample item into a left-justified 32-bit value.
`default_nettype none

module pcmi_convert
    import pcmi_pkg::*;
(
    input  var cfg_t               cfg,
    input  wire logic [31:0]       raw_bytes,
    output logic signed [31:0]     sample_out
);

    logic [5:0]  bits_eff;
    logic [4:0]  bits_m1;
    logic [1:0]  last_byte;
    logic [4:0]  shift;
    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] word_le;
    logic [31:0] word_be;
    logic [31:0] pcm_word;
    logic [31:0] pcm_just;
    logic [15:0] law_lin;
    logic [31:0] result;

    assign b0 = raw_bytes[7:0];
    assign b1 = raw_bytes[15:8];
    assign b2 = raw_bytes[23:16];
    assign b3 = raw_bytes[31:24];

    // Clamp the width to 1..32 and derive byte count and justify shift
    always_comb begin
        if (cfg.sample_bits == 6'd0) begin
            bits_eff = 6'd1;
        end else if (cfg.sample_bits > 6'd32) begin
            bits_eff = 6'd32;
        end else begin
            bits_eff = cfg.sample_bits;
        end
    end

    assign bits_m1   = 5'(bits_eff - 6'd1);
    assign last_byte = bits_m1[4:3];
    assign shift     = ~bits_m1;

    // Assemble the stored bytes in either byte order
    always_comb begin
        case (last_byte)
            2'd0: begin
                word_le = {24'h000000, b0};
                word_be = {24'h000000, b0};
            end
            2'd1: begin
                word_le = {16'h0000, b1, b0};
                word_be = {16'h0000, b0, b1};
            end
            2'd2: begin
                word_le = {8'h00, b2, b1, b0};
                word_be = {8'h00, b0, b1, b2};
            end
            default: begin
                word_le = {b3, b2, b1, b0};
                word_be = {b0, b1, b2, b3};
            end
        endcase
    end

    assign pcm_word = cfg.sample_format[0] ? word_be : word_le;
    assign pcm_just = pcm_word << shift;

    // Expand the companded code held in byte 0
    assign law_lin = (cfg.sample_format == FMT_ALAW) ? alaw_expand(b0) : ulaw_expand(b0);

    // Select the result by format
    always_comb begin
        case (cfg.sample_format)
            FMT_S_LE, FMT_S_BE: result = pcm_just;
            FMT_U_LE, FMT_U_BE: result = pcm_just - UNSIGNED_OFFS;
            FMT_ALAW, FMT_ULAW: result = {law_lin, 16'h0000};
            default:            result = 32'h0000_0000;
        endcase
    end

    assign sample_out = result;

endmodule

`default_nettype wire

>>> hw/rtl/pcm_sample_to_int32.sv
// Top level: streaming PCM and G.711 sample converter to left-justified signed 32-bit.
// An accepted input item passes the input register and then the result register before it is valid on the m_ side.
// Throughput: one item per cycle while the m_ side takes results; input register, conversion logic, result register.
// s_tready stays high unless both stages hold items and the m_ side is stalled.
// Reset (aresetn low, synchronous) empties both stages and sets format 0, width 16.
`default_nettype none

module pcm_sample_to_int32
    import pcmi_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // Configuration write port
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [5:0]         cfg_wdata,

    // Input channel
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,    // [31:0] raw_bytes
    input  wire logic               s_tlast,

    // Result channel
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic signed [31:0]      m_tdata,    // [31:0] sample_out
    output logic                    m_tlast
);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [31:0]        in_data_reg;
    logic               in_last_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_data_reg;
    logic               out_last_reg;
    logic               out_ready;
    logic               in_ready;
    logic signed [31:0] conv_sample;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_format <= FORMAT_RESET;
            cfg_reg.sample_bits   <= BITS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FORMAT: cfg_reg.sample_format <= cfg_wdata[2:0];
                REG_BITS:   cfg_reg.sample_bits   <= cfg_wdata;
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Stage handshakes
    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;

    // Hold the accepted item in the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    pcmi_convert u_convert (
        .cfg        (cfg_reg),
        .raw_bytes  (in_data_reg),
        .sample_out (conv_sample)
    );

    // Advance the converted item into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            out_data_reg <= conv_sample;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Both stages are empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !out_valid_reg))
        else $error("stages not empty after reset");

    // An accepted item lands in the input register
    a_in_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted item lost at input register");

    // A held item moves on whenever the result register can take it
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_ready) |=> out_valid_reg)
        else $error("item not advanced to result register");

    // Back-pressure only when both stages are full and the output is stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the PCM and G.711 sample converter.
`timescale 1ns / 1ps

module tb_top;
    import pcmi_pkg::*;

    localparam int PIPE_LATENCY = 2;
    localparam int IDLE_PCT     = 18;
    localparam int RAND_PHASES  = 31;
    localparam int PHASE_ITEMS  = 30;

    // Format codes the block must treat as unknown
    localparam logic [2:0] FMT_SPARE_6 = 3'd6;
    localparam logic [2:0] FMT_SPARE_7 = 3'd7;

    typedef struct {
        logic [31:0] raw;
        logic        last;
    } raw_item_t;

    typedef struct {
        logic [31:0] sample;
        logic        last;
    } conv_item_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = REG_FORMAT;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic signed [31:0] m_tdata;
    logic        m_tlast;

    // Shadow of the configuration registers
    logic [2:0]  fmt_now  = FORMAT_RESET;
    logic [5:0]  bits_now = BITS_RESET;

    raw_item_t   samples_to_send[$];
    conv_item_t  converted_due[$];
    logic        offer_open  = 1'b0;
    int          error_count = 0;
    logic        tx_calm     = 1'b0;
    logic        rx_calm     = 1'b0;
    int          rx_hold_req = 0;
    int          rx_hold_left = 0;

    pcm_sample_to_int32 u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // A-law code to 16-bit linear
    function automatic logic [15:0] alaw_to_linear(input logic [7:0] code);
        logic [7:0]  a;
        logic [2:0]  seg;
        logic [15:0] mag;
        a   = code ^ ALAW_XOR;
        seg = a[6:4];
        // low nibble sits mid-step: bits 7:4 plus half a step
        mag = {8'h00, a[3:0], 4'b1000};
        if (seg != 3'd0) begin
            mag = (mag + 16'h0100) << (seg - 3'd1);
        end
        return a[7] ? mag : -mag;
    endfunction

    // mu-law code to 16-bit linear
    function automatic logic [15:0] ulaw_to_linear(input logic [7:0] code);
        logic [7:0]  u;
        logic [15:0] t;
        u = ~code;
        t = (16'(u[3:0]) * 16'd8 + ULAW_BIAS) << u[6:4];
        return u[7] ? (ULAW_BIAS - t) : (t - ULAW_BIAS);
    endfunction

    // Expected left-justified sample for one raw word
    function automatic logic [31:0] convert_sample(input logic [2:0] fmt,
                                                   input logic [5:0] bits_cfg,
                                                   input logic [31:0] raw);
        int unsigned width;
        int unsigned nbytes;
        logic [31:0] word;
        logic [31:0] res;
        width = bits_cfg;
        if (width < 1) width = 1;
        if (width > 32) width = 32;
        nbytes = (width + 7) / 8;
        res = '0;
        case (fmt)
            FMT_S_LE, FMT_S_BE, FMT_U_LE, FMT_U_BE: begin
                word = '0;
                for (int k = 0; k < nbytes; k++) begin
                    if (fmt == FMT_S_BE || fmt == FMT_U_BE) begin
                        word = (word << 8) | 32'(raw[8*k +: 8]);
                    end else begin
                        word[8*k +: 8] = raw[8*k +: 8];
                    end
                end
                res = word << (32 - width);
                if (fmt == FMT_U_LE || fmt == FMT_U_BE) begin
                    res = res - UNSIGNED_OFFS;
                end
            end
            FMT_ALAW: res = {alaw_to_linear(raw[7:0]), 16'h0000};
            FMT_ULAW: res = {ulaw_to_linear(raw[7:0]), 16'h0000};
            default:  res = '0;
        endcase
        return res;
    endfunction

    // Sender: offer the oldest pending item, idling at random
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!offer_open) begin
            if (samples_to_send.size() > 0 &&
                (tx_calm || $urandom_range(99) >= IDLE_PCT)) begin
                s_tvalid   <= 1'b1;
                s_tdata    <= samples_to_send[0].raw;
                s_tlast    <= samples_to_send[0].last;
                offer_open = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Input handshake: predict the result of each accepted item
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            converted_due.push_back('{convert_sample(fmt_now, bits_now, s_tdata), s_tlast});
            void'(samples_to_send.pop_front());
            offer_open = 1'b0;
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_hold_req > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_req - 1;
            rx_hold_req  = 0;
        end else begin
            m_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        conv_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (converted_due.size() == 0) begin
                $display("%0t: unexpected result: sample %h last %b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = converted_due.pop_front();
                if (m_tdata !== want.sample) begin
                    $display("%0t: sample_out mismatch: expected %h, actual %h",
                             $time, want.sample, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_out mismatch: expected %b, actual %b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    task automatic add_item(input logic [31:0] raw, input logic last);
        samples_to_send.push_back('{raw, last});
    endtask

    // Hold until every item is sent and converted, then let the pipe settle
    task automatic wait_drained();
        while (samples_to_send.size() > 0 || offer_open || converted_due.size() > 0) begin
            @(negedge aclk);
        end
        repeat (PIPE_LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_FORMAT) begin
            fmt_now = data[2:0];
        end else begin
            bits_now = data;
        end
    endtask

    // Stimulus
    initial begin
        int          r;
        logic [2:0]  fmt;
        logic [5:0]  bits;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: signed LE, 16 bits; unused upper bytes ignored
        add_item(32'h0000_0000, 1'b0);
        add_item(32'hFFFF_FFFF, 1'b1);
        add_item(32'h1234_8000, 1'b0);
        add_item(32'h5A5A_7FFF, 1'b1);
        wait_drained();

        // Unsigned BE at full width: offset wraps modulo 2^32
        write_reg(REG_FORMAT, {3'b000, FMT_U_BE});
        write_reg(REG_BITS, 6'd32);
        add_item(32'h0000_0080, 1'b0);
        add_item(32'hFFFF_FFFF, 1'b0);
        add_item(32'h0102_0304, 1'b1);
        wait_drained();

        // A-law with width zero, which it ignores; segment and sign extremes
        write_reg(REG_FORMAT, {3'b101, FMT_ALAW});
        write_reg(REG_BITS, 6'd0);
        add_item({24'($urandom_range(0, 32'hFFFFFF)), 8'h55}, 1'b0);
        add_item({24'hFFFFFF, 8'hD5}, 1'b1);
        add_item(32'h0000_0000, 1'b0);
        add_item(32'h0000_0080, 1'b0);
        add_item(32'h0000_00FF, 1'b1);
        add_item(32'hABCD_EF7F, 1'b0);
        wait_drained();

        // mu-law extremes
        write_reg(REG_FORMAT, {3'b000, FMT_ULAW});
        add_item(32'hFFFF_FF00, 1'b0);
        add_item(32'h0000_007F, 1'b1);
        add_item(32'h1111_1180, 1'b0);
        add_item(32'h0000_00FF, 1'b1);
        wait_drained();

        // Unknown formats give zero but still pass last through
        write_reg(REG_FORMAT, {3'b000, FMT_SPARE_6});
        add_item(32'hFFFF_FFFF, 1'b1);
        wait_drained();
        write_reg(REG_FORMAT, {3'b111, FMT_SPARE_7});
        add_item(32'h8000_0001, 1'b0);
        wait_drained();

        // Width above 32 clamps; width zero on PCM reads as one bit
        write_reg(REG_FORMAT, {3'b000, FMT_S_BE});
        write_reg(REG_BITS, 6'd63);
        add_item(32'h8877_6655, 1'b0);
        wait_drained();
        write_reg(REG_FORMAT, {3'b000, FMT_S_LE});
        write_reg(REG_BITS, 6'd0);
        add_item(32'hFFFF_FF01, 1'b1);
        add_item(32'h0000_00FE, 1'b0);
        wait_drained();

        // Random phases, each with fresh register settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            r   = $urandom_range(99);
            fmt = (r < 94) ? 3'(r % 6) : 3'(6 + r % 2);
            r   = $urandom_range(99);
            if (r < 5) begin
                bits = 6'd0;
            end else if (r < 10) begin
                bits = 6'($urandom_range(33, 63));
            end else if (r < 20) begin
                bits = r[0] ? 6'd1 : 6'd32;
            end else begin
                bits = 6'($urandom_range(1, 32));
            end
            write_reg(REG_FORMAT, {3'($urandom_range(7)), fmt});
            write_reg(REG_BITS, bits);

            // One phase with no idling on either side
            tx_calm = (ph == 3 || ph == 6);
            rx_calm = (ph == 3);
            // Hold off the receiver long enough to back the input up
            if (ph == 6) rx_hold_req = 80;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                add_item($urandom(), $urandom_range(7) == 0);
            end
            wait_drained();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pcmi_pkg.sv
hw/rtl/pcmi_convert.sv
hw/rtl/pcm_sample_to_int32.sv
verif/tb_top.sv
